// File: hw/rtl/sorted_key_table_insert_lookup_defines.svh
// assertion macros for the sorted key table
// used by the top level only, needs clk and rst_n in scope where expanded
`ifndef SORTED_KEY_TABLE_INSERT_LOOKUP_DEFINES_SVH
`define SORTED_KEY_TABLE_INSERT_LOOKUP_DEFINES_SVH
`ifndef SYNTHESIS
`define SKT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted key table check failed");
`define SKT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted key table check failed");
`else
`define SKT_ASSERT_SAME(label, ante, cons)
`define SKT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/skt_pkg.sv
// shared types and constants of the sorted key table
// no dependencies
`default_nettype none

package skt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int SLOT_W          = 6;
    localparam int STATUS_W        = 3;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_GET = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FOUND     = 3'd4
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] usage;
        logic [VAL_W-1:0] low;
        logic [VAL_W-1:0] high;
        logic [VAL_W-1:0] rest;
    } rec_t;

    // per-cell compare results
    typedef struct packed {
        logic lt;        // occupied and key below probe
        logic hit;       // occupied and key equal to probe
        logic boundary;  // first cell not below probe, new record lands here
    } cell_flags_t;

endpackage

`default_nettype wire

// File: hw/rtl/skt_cell.sv
// one slot of the sorted record chain: holds a record, compares it with the probe
// and on insert keeps, takes the new record or takes its lower neighbour's record
// depends on skt_pkg
`default_nettype none

module skt_cell #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
    parameter int INDEX       = 0,
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
    input  wire                       clk,
    input  wire [skt_pkg::KEY_W-1:0]  probe_key,
    input  wire [CNT_W-1:0]           count,
    input  wire                       insert_en,
    input  skt_pkg::rec_t             new_rec,
    input  skt_pkg::rec_t             prev_rec,
    input  wire                       prev_lt,
    output skt_pkg::rec_t             rec,
    output skt_pkg::cell_flags_t      flags
);

    skt_pkg::rec_t rec_reg;
    logic          occupied;

    assign occupied       = count > CNT_W'(INDEX);
    assign flags.lt       = occupied && ($signed(rec_reg.key) < $signed(probe_key));
    assign flags.hit      = occupied && (rec_reg.key == probe_key);
    assign flags.boundary = !flags.lt && prev_lt;
    assign rec            = rec_reg;

    always_ff @(posedge clk)
    begin
        if (insert_en && !flags.lt)
        begin
            rec_reg <= flags.boundary ? new_rec : prev_rec;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/skt_select.sv
// gathers the chain's one-hot hit and boundary vectors into slot numbers
// and picks the matching record
// depends on skt_pkg
`default_nettype none

module skt_select #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
    input  wire [TABLE_DEPTH-1:0] hit_vec,
    input  wire [TABLE_DEPTH-1:0] bnd_vec,
    input  skt_pkg::rec_t         recs [TABLE_DEPTH],
    output logic                  hit_any,
    output logic [IDX_W-1:0]      hit_idx,
    output skt_pkg::rec_t         hit_rec,
    output logic [IDX_W-1:0]      bnd_idx
);

    // vectors are one-hot or empty, so plain or-reduction serves as the mux
    always_comb
    begin
        hit_any = |hit_vec;
        hit_idx = '0;
        bnd_idx = '0;
        hit_rec = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit_idx = hit_idx | (hit_vec[i] ? IDX_W'(i) : '0);
            bnd_idx = bnd_idx | (bnd_vec[i] ? IDX_W'(i) : '0);
            hit_rec = hit_rec | (hit_vec[i] ? recs[i] : '0);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sorted_key_table_insert_lookup.sv
// top level of the sorted key table: request register, chain of record cells,
// select logic and result register
// depends on skt_pkg, skt_cell, skt_select and the defines header
//
// channel  dir  handshake                   payload
// s        in   s_tvalid / s_tready         s_tuser cmd, s_tdata key and record
// m        out  m_tvalid / m_tready         m_tuser status, m_tdata slot and record
//
// a request is registered on acceptance and resolved once the result register is
// free, when the whole cell chain compares and shifts at once; a new request may be
// taken in that same cycle, so one request per cycle is sustained while results are
// taken. the result register holds a result until taken; a stalled result stalls the
// request register and then s_tready. reset empties the table at once, no sweep.
`include "sorted_key_table_insert_lookup_defines.svh"
`default_nettype none

module sorted_key_table_insert_lookup #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [159:0] s_tdata,   // button_key, usage_code, range_low, range_high, rest_value
    input  wire  [0:0]   s_tuser,   // cmd
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [135:0] m_tdata,   // slot_index, found_usage, found_low, found_high,
                                    // found_rest, two zero bits
    output logic [2:0]   m_tuser    // status
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    // request register
    logic            item_valid_reg;
    logic            item_cmd_reg;
    skt_pkg::rec_t   item_rec_reg;

    logic [CNT_W-1:0] entry_count_reg;

    // result register
    logic                         out_valid_reg;
    skt_pkg::status_t             out_status_reg;
    logic [skt_pkg::SLOT_W-1:0]   out_slot_reg;
    skt_pkg::rec_t                out_rec_reg;

    logic                         s_fire;
    logic                         exec;
    logic                         full;
    logic                         insert_en;

    skt_pkg::rec_t                cell_rec   [TABLE_DEPTH];
    skt_pkg::cell_flags_t         cell_flags [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]       hit_vec;
    logic [TABLE_DEPTH-1:0]       bnd_vec;

    logic                         hit_any;
    logic [IDX_W-1:0]             hit_idx;
    logic [IDX_W-1:0]             bnd_idx;
    skt_pkg::rec_t                hit_rec;

    skt_pkg::status_t             status_next;
    logic [skt_pkg::SLOT_W-1:0]   slot_next;
    skt_pkg::rec_t                rec_next;

    assign exec     = item_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || exec;
    assign s_fire   = s_tvalid && s_tready;
    assign full     = entry_count_reg == CNT_W'(TABLE_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (exec)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_cmd_reg       <= s_tuser[0];
            item_rec_reg.key   <= s_tdata[31:0];
            item_rec_reg.usage <= s_tdata[63:32];
            item_rec_reg.low   <= s_tdata[95:64];
            item_rec_reg.high  <= s_tdata[127:96];
            item_rec_reg.rest  <= s_tdata[159:128];
        end
    end

    // cell chain, each cell sees its lower neighbour's record and compare flag
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        skt_pkg::rec_t prev_rec;
        logic          prev_lt;

        if (i == 0)
        begin : g_first
            assign prev_rec = item_rec_reg;
            assign prev_lt  = 1'b1;
        end
        else
        begin : g_rest
            assign prev_rec = cell_rec[i-1];
            assign prev_lt  = cell_flags[i-1].lt;
        end

        skt_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .INDEX       (i)
        ) u_cell (
            .clk       (clk),
            .probe_key (item_rec_reg.key),
            .count     (entry_count_reg),
            .insert_en (insert_en),
            .new_rec   (item_rec_reg),
            .prev_rec  (prev_rec),
            .prev_lt   (prev_lt),
            .rec       (cell_rec[i]),
            .flags     (cell_flags[i])
        );

        assign hit_vec[i] = cell_flags[i].hit;
        assign bnd_vec[i] = cell_flags[i].boundary;
    end

    skt_select #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_select (
        .hit_vec (hit_vec),
        .bnd_vec (bnd_vec),
        .recs    (cell_rec),
        .hit_any (hit_any),
        .hit_idx (hit_idx),
        .hit_rec (hit_rec),
        .bnd_idx (bnd_idx)
    );

    always_comb
    begin
        insert_en   = 1'b0;
        status_next = skt_pkg::ST_NOT_FOUND;
        slot_next   = '0;
        rec_next    = '0;
        if (item_cmd_reg == skt_pkg::CMD_GET)
        begin
            if (hit_any)
            begin
                status_next = skt_pkg::ST_FOUND;
                slot_next   = skt_pkg::SLOT_W'(hit_idx);
                rec_next    = hit_rec;
            end
        end
        else if (hit_any)
        begin
            status_next = skt_pkg::ST_DUPLICATE;
        end
        else if (full)
        begin
            status_next = skt_pkg::ST_FULL;
        end
        else
        begin
            insert_en   = exec;
            status_next = skt_pkg::ST_INSERTED;
            slot_next   = skt_pkg::SLOT_W'(bnd_idx);
            rec_next    = item_rec_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (insert_en)
            begin
                entry_count_reg <= entry_count_reg + 1'b1;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_status_reg <= status_next;
            out_slot_reg   <= slot_next;
            out_rec_reg    <= rec_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_rec_reg.rest, out_rec_reg.high, out_rec_reg.low,
                       out_rec_reg.usage, out_slot_reg};

    `SKT_ASSERT_SAME(a_count_bound, 1'b1, entry_count_reg <= CNT_W'(TABLE_DEPTH))
    `SKT_ASSERT_SAME(a_hit_unique, item_valid_reg, $onehot0(hit_vec))
    `SKT_ASSERT_SAME(a_insert_slot, insert_en, $onehot(bnd_vec))
    `SKT_ASSERT_NEXT(a_count_step, insert_en,
        entry_count_reg == $past(entry_count_reg) + 1'b1)

endmodule

`default_nettype wire
